FILE: hdl/aruf_pkg.sv
// Shared types and constants for the advertising report identifier filter.
// Depends on nothing; imported by adv_report_uuid_filter, aruf_checker and tb_top.
package aruf_pkg;

    localparam int MAX_REPORT_BYTES = 31;
    localparam int CNT_W = $clog2(MAX_REPORT_BYTES + 1);

    localparam logic [15:0]       TARGET_ID_RST   = 16'hA000;
    localparam logic signed [7:0] RSSI_FLOOR_RST  = -8'sd90;
    localparam logic [7:0]        PRIMARY_TYPE_RST  = 8'd6;
    localparam logic [7:0]        FALLBACK_TYPE_RST = 8'd9;

    // Configuration register indexes.
    localparam logic [1:0] REG_TARGET_ID     = 2'd0;
    localparam logic [1:0] REG_RSSI_FLOOR    = 2'd1;
    localparam logic [1:0] REG_PRIMARY_TYPE  = 2'd2;
    localparam logic [1:0] REG_FALLBACK_TYPE = 2'd3;

    // Values of field_source.
    localparam logic [1:0] SRC_NONE     = 2'd0;
    localparam logic [1:0] SRC_PRIMARY  = 2'd1;
    localparam logic [1:0] SRC_FALLBACK = 2'd2;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] bytes_left;
        logic       in_primary;
        logic       in_fallback;
        logic       primary_found;
        logic       fallback_found;
        logic       primary_hit;
        logic       fallback_hit;
        logic [7:0] low_half;
        logic       pair_odd;
    } parse_t;

    localparam parse_t PARSE_RST = '{
        phase:          PH_LEN,
        bytes_left:     8'd0,
        in_primary:     1'b0,
        in_fallback:    1'b0,
        primary_found:  1'b0,
        fallback_found: 1'b0,
        primary_hit:    1'b0,
        fallback_hit:   1'b0,
        low_half:       8'd0,
        pair_odd:       1'b0
    };

endpackage

FILE: hdl/adv_report_uuid_filter.sv
// Advertising report identifier filter: one input register, the parse logic and
// one result register. Depends on aruf_pkg.
// A result is registered from the final item of a report as that item leaves the input register.
// Throughput: one item per cycle; a final item waits in the input register only
// while an earlier verdict is still held in the result register.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// parse state and empties both registers.
module adv_report_uuid_filter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_payload_byte,
    input  logic                s_final_byte,
    input  logic signed [7:0]   s_signal_dbm,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_connect_request,
    output logic [1:0]          m_field_source,
    output logic                m_target_seen
);
    import aruf_pkg::*;

    logic [15:0]       target_id_reg;
    logic signed [7:0] rssi_floor_reg;
    logic [7:0]        primary_type_reg;
    logic [7:0]        fallback_type_reg;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_final_reg;
    logic signed [7:0] in_dbm_reg;

    parse_t            st_reg, st_next, parsed;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg;
    logic              out_connect_reg, out_connect_next;
    logic [1:0]        out_source_reg, out_source_next;
    logic              out_seen_reg, out_seen_next;

    logic              advance;
    logic              out_free;
    logic [15:0]       pair_id;

    assign out_free = !out_valid_reg || m_ready;
    // Non-final items never produce a result, so only a final item can stall.
    assign advance  = in_valid_reg && (!in_final_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign pair_id  = {in_byte_reg, st_reg.low_half};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_id_reg     <= TARGET_ID_RST;
            rssi_floor_reg    <= RSSI_FLOOR_RST;
            primary_type_reg  <= PRIMARY_TYPE_RST;
            fallback_type_reg <= FALLBACK_TYPE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TARGET_ID:     target_id_reg     <= cfg_wr_data;
                REG_RSSI_FLOOR:    rssi_floor_reg    <= $signed(cfg_wr_data[7:0]);
                REG_PRIMARY_TYPE:  primary_type_reg  <= cfg_wr_data[7:0];
                REG_FALLBACK_TYPE: fallback_type_reg <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // Next parse state for the byte held in the input register.
    always_comb begin
        parsed = st_reg;
        case (st_reg.phase)
            PH_TYPE: begin
                parsed.bytes_left = st_reg.bytes_left - 8'd1;
                parsed.pair_odd   = 1'b0;
                if (!st_reg.primary_found && in_byte_reg == primary_type_reg) begin
                    parsed.primary_found = 1'b1;
                    parsed.in_primary    = 1'b1;
                end
                if (!st_reg.fallback_found && in_byte_reg == fallback_type_reg) begin
                    parsed.fallback_found = 1'b1;
                    parsed.in_fallback    = 1'b1;
                end
                parsed.phase = PH_DATA;
            end
            PH_DATA: begin
                if (st_reg.in_primary || st_reg.in_fallback) begin
                    if (!st_reg.pair_odd) begin
                        parsed.low_half = in_byte_reg;
                        parsed.pair_odd = 1'b1;
                    end else begin
                        if (pair_id == target_id_reg) begin
                            if (st_reg.in_primary) parsed.primary_hit = 1'b1;
                            if (st_reg.in_fallback) parsed.fallback_hit = 1'b1;
                        end
                        parsed.pair_odd = 1'b0;
                    end
                end
                parsed.bytes_left = st_reg.bytes_left - 8'd1;
            end
            default: begin
                // Length byte; a zero length is skipped.
                if (in_byte_reg != 8'd0) begin
                    parsed.bytes_left = in_byte_reg;
                    parsed.phase      = PH_TYPE;
                end else begin
                    parsed.phase = PH_LEN;
                end
            end
        endcase
        // The structure ends when its last byte has been consumed.
        if ((st_reg.phase == PH_TYPE || st_reg.phase == PH_DATA) &&
            parsed.bytes_left == 8'd0) begin
            parsed.phase       = PH_LEN;
            parsed.in_primary  = 1'b0;
            parsed.in_fallback = 1'b0;
            parsed.pair_odd    = 1'b0;
        end
        // Bytes beyond the report length limit leave the parse state alone.
        if (cnt_reg >= CNT_W'(MAX_REPORT_BYTES)) begin
            parsed = st_reg;
        end

        st_next  = st_reg;
        cnt_next = cnt_reg;
        if (advance) begin
            if (in_final_reg) begin
                st_next  = PARSE_RST;
                cnt_next = '0;
            end else begin
                st_next = parsed;
                if (cnt_reg < CNT_W'(MAX_REPORT_BYTES)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Verdict for a final item.
    always_comb begin
        if (parsed.primary_found) begin
            out_source_next = SRC_PRIMARY;
            out_seen_next   = parsed.primary_hit;
        end else if (parsed.fallback_found) begin
            out_source_next = SRC_FALLBACK;
            out_seen_next   = parsed.fallback_hit;
        end else begin
            out_source_next = SRC_NONE;
            out_seen_next   = 1'b0;
        end
        out_connect_next = out_seen_next && (in_dbm_reg >= rssi_floor_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= PARSE_RST;
            cnt_reg       <= '0;
        end else begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && in_final_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_payload_byte;
            in_final_reg <= s_final_byte;
            in_dbm_reg   <= s_signal_dbm;
        end
        if (advance && in_final_reg) begin
            out_connect_reg <= out_connect_next;
            out_source_reg  <= out_source_next;
            out_seen_reg    <= out_seen_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_connect_request = out_connect_reg;
    assign m_field_source    = out_source_reg;
    assign m_target_seen     = out_seen_reg;

endmodule

FILE: hdl/aruf_checker.sv
// Port-level checks for the advertising report identifier filter, and the bind
// that attaches them to adv_report_uuid_filter. Depends on aruf_pkg.
module aruf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_connect_request,
    input logic [1:0] m_field_source,
    input logic       m_target_seen
);
    import aruf_pkg::*;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_field_source)
            && $stable(m_target_seen) && $stable(m_connect_request))
        else $error("result changed while stalled");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present right after reset");

    a_source_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_field_source == SRC_NONE || m_field_source == SRC_PRIMARY
            || m_field_source == SRC_FALLBACK)
        else $error("unused field source code");

    a_none_not_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_field_source == SRC_NONE |-> !m_target_seen)
        else $error("target seen without a deciding field");

    a_connect_needs_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_connect_request |-> m_target_seen)
        else $error("connect request without the target");

endmodule

bind adv_report_uuid_filter aruf_checker u_aruf_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_connect_request (m_connect_request),
    .m_field_source    (m_field_source),
    .m_target_seen     (m_target_seen)
);

FILE: test/tb_top.sv
// Self-checking testbench for adv_report_uuid_filter: directed reports, then random reports
// under several register settings. Depends on aruf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_top;
    import aruf_pkg::*;

    localparam longint WATCHDOG_NS = 64'd20_000_000;
    localparam int     ITEMS_PER_PHASE = 130;
    localparam int     PHASES = 7;
    localparam int     HOLD_CYCLES = 400;

    typedef struct packed {
        logic       connect;
        logic [1:0] source;
        logic       seen;
    } verdict_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic signed [7:0] dbm;
        logic              typed;
        verdict_t          want;
    } row_t;

    // Parse state of the predictor, cleared to zero after reset and after each verdict.
    typedef struct packed {
        phase_t     phase;
        logic [7:0] left;
        logic       in_pri;
        logic       in_fb;
        logic       pri_found;
        logic       fb_found;
        logic       pri_hit;
        logic       fb_hit;
        logic [7:0] low;
        logic       odd;
        logic [7:0] count;
    } scan_state_t;

    // mode 0: fixed values, 1: all random, 2: random with both types equal.
    typedef struct packed {
        logic [15:0]       target;
        logic signed [7:0] floor;
        logic [7:0]        primary;
        logic [7:0]        fallback;
        logic [1:0]        mode;
    } reg_plan_t;

    localparam reg_plan_t REG_PLAN [PHASES] = '{
        '{16'hA000, -8'sd90,  8'd6,   8'd9,   2'd0},
        '{16'h0000, -8'sd128, 8'd0,   8'd255, 2'd0},
        '{16'hFFFF, 8'sd127,  8'd255, 8'd0,   2'd0},
        '{16'h0000, 8'sd0,    8'd0,   8'd0,   2'd2},
        '{16'h1234, 8'sd0,    8'd2,   8'd3,   2'd0},
        '{16'h0000, 8'sd0,    8'd0,   8'd0,   2'd1},
        '{16'hA000, -8'sd90,  8'd6,   8'd9,   2'd0}
    };

    // Directed reports under the reset settings.
    localparam int DIRECTED_ROWS = 27;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        // Lone final byte right after reset: no field at all.
        '{8'h00, 1'b1, -8'sd128, 1'b1, '{1'b0, SRC_NONE, 1'b0}},
        // Primary field with the target, strongest signal.
        '{8'h03, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h06, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h00, 1'b0, 8'sd0,   1'b0, '0},
        '{8'hA0, 1'b1, 8'sd127, 1'b1, '{1'b1, SRC_PRIMARY, 1'b1}},
        // Zero-length structure first, then a fallback hit exactly at the floor.
        '{8'h00, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h03, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h09, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h00, 1'b0, 8'sd0,   1'b0, '0},
        '{8'hA0, 1'b1, -8'sd90, 1'b1, '{1'b1, SRC_FALLBACK, 1'b1}},
        // Odd trailing byte, then a length of 0xFF cut off by the end of the report.
        '{8'h04, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h06, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h00, 1'b0, 8'sd0,   1'b0, '0},
        '{8'hA0, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h55, 1'b0, 8'sd0,   1'b0, '0},
        '{8'hFF, 1'b1, -8'sd91, 1'b0, '0},
        // Fallback structure truncated after its first data byte.
        '{8'h05, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h09, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h00, 1'b1, 8'sd0,   1'b0, '0},
        // Fallback holds the target but the primary field without it decides.
        '{8'h03, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h09, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h00, 1'b0, 8'sd0,   1'b0, '0},
        '{8'hA0, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h03, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h06, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h34, 1'b0, 8'sd0,   1'b0, '0},
        '{8'h12, 1'b1, 8'sd5,   1'b0, '0}
    };

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [15:0]       cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_payload_byte;
    logic              s_final_byte;
    logic signed [7:0] s_signal_dbm;
    logic              m_valid;
    logic              m_ready;
    logic              m_connect_request;
    logic [1:0]        m_field_source;
    logic              m_target_seen;

    logic [15:0]       cfg_target;
    logic signed [7:0] cfg_floor;
    logic [7:0]        cfg_primary;
    logic [7:0]        cfg_fallback;
    scan_state_t       scan;
    verdict_t          verdicts_due [$];
    logic [7:0]        report_bytes [$];

    int errors = 0;
    int items_sent = 0;
    int reports_sent = 0;
    int verdicts_by_source [3] = '{0, 0, 0};
    int connects = 0;
    int settings_used = 0;
    bit tx_steady = 0;
    bit hold_request = 0;

    adv_report_uuid_filter dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_payload_byte    (s_payload_byte),
        .s_final_byte      (s_final_byte),
        .s_signal_dbm      (s_signal_dbm),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_connect_request (m_connect_request),
        .m_field_source    (m_field_source),
        .m_target_seen     (m_target_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("%0t: timeout, %0d verdicts still due", $time, verdicts_due.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // Advances the predictor by one accepted item.
    task automatic scan_item(input logic [7:0] b, input logic last,
                             input logic signed [7:0] dbm,
                             output bit has_verdict, output verdict_t v);
        logic seen;
        has_verdict = 1'b0;
        v = '0;
        if (scan.count < MAX_REPORT_BYTES) begin
            case (scan.phase)
                PH_TYPE: begin
                    scan.left = scan.left - 8'd1;
                    scan.odd = 1'b0;
                    if (!scan.pri_found && b == cfg_primary) begin
                        scan.pri_found = 1'b1;
                        scan.in_pri = 1'b1;
                    end
                    if (!scan.fb_found && b == cfg_fallback) begin
                        scan.fb_found = 1'b1;
                        scan.in_fb = 1'b1;
                    end
                    scan.phase = PH_DATA;
                end
                PH_DATA: begin
                    if (scan.in_pri || scan.in_fb) begin
                        if (!scan.odd) begin
                            scan.low = b;
                            scan.odd = 1'b1;
                        end else begin
                            if ({b, scan.low} == cfg_target) begin
                                if (scan.in_pri) scan.pri_hit = 1'b1;
                                if (scan.in_fb) scan.fb_hit = 1'b1;
                            end
                            scan.odd = 1'b0;
                        end
                    end
                    scan.left = scan.left - 8'd1;
                end
                default: begin
                    // A zero length byte leaves the parser waiting for the next length.
                    if (b != 8'd0) begin
                        scan.left = b;
                        scan.phase = PH_TYPE;
                    end else begin
                        scan.phase = PH_LEN;
                    end
                end
            endcase
            if (scan.phase != PH_LEN && scan.phase != PH_TYPE && scan.left == 8'd0) begin
                scan.phase = PH_LEN;
                scan.in_pri = 1'b0;
                scan.in_fb = 1'b0;
                scan.odd = 1'b0;
            end
        end
        if (scan.count != 8'hFF) scan.count = scan.count + 8'd1;
        if (last) begin
            if (scan.pri_found) begin
                v.source = SRC_PRIMARY;
                seen = scan.pri_hit;
            end else if (scan.fb_found) begin
                v.source = SRC_FALLBACK;
                seen = scan.fb_hit;
            end else begin
                v.source = SRC_NONE;
                seen = 1'b0;
            end
            v.seen = seen;
            v.connect = seen && (dbm >= cfg_floor);
            has_verdict = 1'b1;
            scan = '0;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_TARGET_ID:     cfg_target = data;
            REG_RSSI_FLOOR:    cfg_floor = data[7:0];
            REG_PRIMARY_TYPE:  cfg_primary = data[7:0];
            REG_FALLBACK_TYPE: cfg_fallback = data[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] b, input logic last,
                             input logic signed [7:0] dbm, input logic typed,
                             input verdict_t want);
        int unsigned gap;
        bit has_verdict;
        verdict_t v;
        gap = tx_steady ? 0 : $urandom_range(0, 18);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload_byte <= b;
        s_final_byte <= last;
        s_signal_dbm <= dbm;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        scan_item(b, last, dbm, has_verdict, v);
        if (has_verdict) begin
            verdicts_due.push_back(typed ? want : v);
            reports_sent++;
        end
    endtask

    // Drops valid and waits until every verdict has come back or the limit is reached.
    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0 && n < limit) begin
            @(posedge aclk);
            n++;
        end
    endtask

    // Mostly well-formed reports with fields of the configured types; some are cut short,
    // some run past the parse window, some are plain noise.
    task automatic build_report();
        int unsigned kind;
        int unsigned len;
        int unsigned pick;
        int unsigned cut;
        logic [7:0]  ty;
        bit          hit;
        report_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 12)) report_bytes.push_back(8'($urandom));
        end else begin
            if (kind < 20) begin
                len = $urandom_range(24, 30);
                report_bytes.push_back(8'(len));
                repeat (len) report_bytes.push_back(8'($urandom));
            end
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 9) == 0) begin
                    report_bytes.push_back(8'h00);
                end else begin
                    len = $urandom_range(1, 8);
                    pick = $urandom_range(0, 9);
                    if (pick < 4) ty = cfg_primary;
                    else if (pick < 7) ty = cfg_fallback;
                    else ty = 8'($urandom);
                    report_bytes.push_back(8'(len));
                    report_bytes.push_back(ty);
                    hit = 1'b0;
                    for (int i = 0; i < int'(len) - 1; i++) begin
                        if (i % 2 == 0) begin
                            hit = ($urandom_range(0, 2) == 0);
                            report_bytes.push_back(hit ? cfg_target[7:0] : 8'($urandom));
                        end else begin
                            report_bytes.push_back(hit ? cfg_target[15:8] : 8'($urandom));
                        end
                    end
                end
            end
            if (kind >= 20 && kind < 36 && report_bytes.size() > 1) begin
                cut = $urandom_range(1, report_bytes.size() - 1);
                while (report_bytes.size() > cut) void'(report_bytes.pop_back());
            end
        end
    endtask

    function automatic logic signed [7:0] pick_dbm();
        int s;
        if ($urandom_range(0, 1) == 0) s = int'(cfg_floor) + int'($urandom_range(0, 2)) - 1;
        else s = int'($signed(8'($urandom)));
        if (s > 127) s = 127;
        if (s < -128) s = -128;
        return 8'(s);
    endfunction

    task automatic check_verdict();
        verdict_t want;
        if (verdicts_due.size() == 0) begin
            $display("%0t: verdict with none expected: connect %0d source %0d seen %0d",
                     $time, m_connect_request, m_field_source, m_target_seen);
            errors++;
        end else begin
            want = verdicts_due.pop_front();
            if (m_connect_request !== want.connect) begin
                $display("%0t: connect_request expected %0d, got %0d",
                         $time, want.connect, m_connect_request);
                errors++;
            end
            if (m_field_source !== want.source) begin
                $display("%0t: field_source expected %0d, got %0d",
                         $time, want.source, m_field_source);
                errors++;
            end
            if (m_target_seen !== want.seen) begin
                $display("%0t: target_seen expected %0d, got %0d",
                         $time, want.seen, m_target_seen);
                errors++;
            end
            if (want.source <= SRC_FALLBACK) verdicts_by_source[want.source]++;
            if (want.connect) connects++;
        end
    endtask

    // Result side: random back-pressure, calm stretches, and one long hold-off.
    initial begin
        int unsigned gap;
        bit rx_steady;
        bit held;
        rx_steady = 1'b0;
        held = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 11) == 0) rx_steady = ~rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 18);
            @(negedge aclk);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_verdict();
            if (hold_request && !held) begin
                held = 1'b1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
        end
    end

    initial begin
        reg_plan_t plan;
        int budget;
        logic signed [7:0] dbm;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_TARGET_ID;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_payload_byte = '0;
        s_final_byte = 1'b0;
        s_signal_dbm = '0;
        cfg_target = TARGET_ID_RST;
        cfg_floor = RSSI_FLOOR_RST;
        cfg_primary = PRIMARY_TYPE_RST;
        cfg_fallback = FALLBACK_TYPE_RST;
        scan = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].dbm,
                      DIRECTED[r].typed, DIRECTED[r].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained(20000);
                repeat (4) @(posedge aclk);
                plan = REG_PLAN[ph];
                if (plan.mode != 2'd0) begin
                    plan.target = 16'($urandom);
                    plan.floor = 8'($urandom);
                    plan.primary = 8'($urandom);
                    plan.fallback = (plan.mode == 2'd2) ? plan.primary : 8'($urandom);
                end
                write_reg(REG_TARGET_ID, plan.target);
                write_reg(REG_RSSI_FLOOR, {{8{plan.floor[7]}}, plan.floor});
                write_reg(REG_PRIMARY_TYPE, {8'h00, plan.primary});
                write_reg(REG_FALLBACK_TYPE, {8'h00, plan.fallback});
                if (ph == 2) hold_request = 1'b1;
            end
            settings_used++;
            budget = items_sent + ITEMS_PER_PHASE;
            while (items_sent < budget) begin
                build_report();
                tx_steady = ($urandom_range(0, 2) == 0);
                dbm = pick_dbm();
                for (int i = 0; i < report_bytes.size(); i++)
                    send_item(report_bytes[i], i == report_bytes.size() - 1,
                              (i == report_bytes.size() - 1) ? dbm : 8'($urandom),
                              1'b0, '0);
                // Now and then the sender waits for the result side to catch up.
                if ($urandom_range(0, 24) == 0) wait_drained(20000);
            end
        end

        wait_drained(20000);
        repeat (8) @(posedge aclk);
        if (verdicts_due.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
            errors += verdicts_due.size();
        end
        $display("Covered %0d items in %0d reports across %0d register settings.",
                 items_sent, reports_sent, settings_used);
        $display("Verdicts: %0d without a field, %0d primary, %0d fallback, %0d connects.",
                 verdicts_by_source[0], verdicts_by_source[1], verdicts_by_source[2],
                 connects);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
